FILE: hdl/mep_pkg.sv
`timescale 1ns / 1ps

package mep_pkg;

    localparam int FRAC_BITS  = 28;
    localparam int WORD_BITS  = FRAC_BITS + 4;
    localparam int PROD_BITS  = 2 * WORD_BITS;
    localparam int INDEX_BITS = 10;

    localparam int CFG_BITS   = 32;
    localparam int STEP_BITS  = 29;
    localparam int COUNT_BITS = 12;
    localparam int DIGIT_BITS = 4;
    localparam int COORD_BITS = 10;

    localparam logic signed [CFG_BITS-1:0] ORIGIN_RE_RST = -32'sd671088640;
    localparam logic signed [CFG_BITS-1:0] ORIGIN_IM_RST = -32'sd295279002;
    localparam logic [STEP_BITS-1:0]       STEP_RST      = 29'd2013266;
    localparam logic [COUNT_BITS-1:0]      LIMIT_RST     = 12'd1000;

    localparam logic signed [PROD_BITS-1:0] QMAX =
        PROD_BITS'((64'sd1 <<< (WORD_BITS - 1)) - 64'sd1);
    localparam logic signed [PROD_BITS-1:0] QMIN = -QMAX - PROD_BITS'(1);
    localparam logic signed [WORD_BITS:0]   FOUR = (WORD_BITS+1)'(4) <<< FRAC_BITS;
    localparam logic signed [PROD_BITS-1:0] ROUND_ZERO =
        PROD_BITS'((64'sd1 <<< FRAC_BITS) - 64'sd1);

    // floor(n/10) = (n * 52429) >> 19, exact for n below 43690
    localparam int RECIP_BITS  = 16;
    localparam int RECIP_SHIFT = 19;
    localparam logic [RECIP_BITS-1:0] RECIP_TEN = 16'd52429;

    typedef logic signed [WORD_BITS-1:0] word_t;
    typedef logic signed [PROD_BITS-1:0] prod_t;

    typedef enum logic [1:0] {
        CFG_ORIGIN_RE,
        CFG_ORIGIN_IM,
        CFG_PIXEL_STEP,
        CFG_ITER_LIMIT
    } cfg_reg_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CX,
        ST_CY,
        ST_CI,
        ST_XX,
        ST_YY,
        ST_XY,
        ST_UPD,
        ST_DIG,
        ST_DONE
    } state_t;

    // saturate a wide signed value to the word bounds
    function automatic word_t sat_word(input prod_t v);
        prod_t r;
        r = v;
        if (v > QMAX) begin
            r = QMAX;
        end else if (v < QMIN) begin
            r = QMIN;
        end
        return WORD_BITS'(r);
    endfunction

    // exact product -> truncate toward zero -> saturate
    function automatic word_t fix_product(input prod_t p);
        prod_t t;
        t = p[PROD_BITS-1] ? p + ROUND_ZERO : p;
        return sat_word(t >>> FRAC_BITS);
    endfunction

    function automatic word_t sat_add(input word_t a, input word_t b);
        return sat_word(PROD_BITS'(a) + PROD_BITS'(b));
    endfunction

    function automatic word_t sat_sub(input word_t a, input word_t b);
        return sat_word(PROD_BITS'(a) - PROD_BITS'(b));
    endfunction

    function automatic logic [COUNT_BITS-1:0] div10(input logic [COUNT_BITS-1:0] n);
        logic [COUNT_BITS+RECIP_BITS-1:0] m;
        m = (COUNT_BITS+RECIP_BITS)'(n) * (COUNT_BITS+RECIP_BITS)'(RECIP_TEN);
        return COUNT_BITS'(m >> RECIP_SHIFT);
    endfunction

endpackage

FILE: hdl/mandelbrot_escape_pixel_core.sv
`timescale 1ns / 1ps

// Mandelbrot escape-time pixel core. A request on the s_axis side carries a pixel
// column and row; c = origin + index * pixel_step is formed in signed Q4.28 and
// z = z^2 + c is iterated from zero until |z|^2 reaches 4 or the iteration limit
// is hit. All multiplications run through one registered 32x32 multiplier, used three
// times per iteration (x*x, y*y, x*y) plus an update step. A result passes in order
// through forming c, the iterations, the final escape test for a point that escapes,
// the decimal digits and the load of the output register. The core holds one pixel
// at a time; s_axis_tready is high only while it is idle. The finished result sits
// in an output register, so a new pixel can be taken while the previous result
// still waits on m_axis_tready. Configuration writes must be made only while the
// core is idle.

module mandelbrot_escape_pixel_core (
    input  logic        aclk,
    input  logic        aresetn,
    // config write port
    input  logic        cfg_we,
    input  logic [1:0]  cfg_addr,
    input  logic [31:0] cfg_wdata,
    // pixel requests
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [23:0] s_axis_tdata,   // [9:0] column, [19:10] row, [23:20] zero
    // results
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata,   // [11:0] escape_count, [15:12] red_tenths,
                                        // [19:16] green_tenths, [23:20] blue_tenths
    output logic        m_axis_tuser    // [0] escaped
);
    import mep_pkg::*;

    localparam logic [WORD_BITS-1:0] IDX_MASK =
        WORD_BITS'((64'd1 << INDEX_BITS) - 64'd1);

    // configuration
    logic signed [CFG_BITS-1:0] origin_re_reg, origin_im_reg;
    logic [STEP_BITS-1:0]       step_reg;
    logic [COUNT_BITS-1:0]      limit_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            origin_re_reg <= ORIGIN_RE_RST;
            origin_im_reg <= ORIGIN_IM_RST;
            step_reg      <= STEP_RST;
            limit_reg     <= LIMIT_RST;
        end else if (cfg_we) begin
            unique case (cfg_reg_t'(cfg_addr))
                CFG_ORIGIN_RE:  origin_re_reg <= cfg_wdata;
                CFG_ORIGIN_IM:  origin_im_reg <= cfg_wdata;
                CFG_PIXEL_STEP: step_reg      <= cfg_wdata[STEP_BITS-1:0];
                CFG_ITER_LIMIT: limit_reg     <= cfg_wdata[COUNT_BITS-1:0];
                default: ;
            endcase
        end
    end

    // sequencer and datapath registers
    state_t                 state_reg, state_next;
    logic [COORD_BITS-1:0]  col_reg, col_next, row_reg, row_next;
    word_t                  cx_reg, cx_next, cy_reg, cy_next;
    word_t                  x_reg, x_next, y_reg, y_next;
    word_t                  xx_reg, xx_next, yy_reg, yy_next;
    logic [COUNT_BITS-1:0]  count_reg, count_next;
    logic                   esc_reg, esc_next;
    logic [COUNT_BITS-1:0]  q_reg, q_next;
    logic [1:0]             dig_cnt_reg, dig_cnt_next;
    logic [DIGIT_BITS-1:0]  hund_reg, hund_next, tens_reg, tens_next;
    logic [DIGIT_BITS-1:0]  unit_reg, unit_next;

    // output register
    logic                   out_valid_reg, out_valid_next;
    logic [COUNT_BITS-1:0]  out_count_reg;
    logic                   out_esc_reg;
    logic [DIGIT_BITS-1:0]  out_red_reg, out_green_reg, out_blue_reg;
    logic                   out_load;

    // shared multiplier
    word_t mul_a, mul_b;
    prod_t prod;

    mep_mul u_mul (
        .aclk (aclk),
        .a    (mul_a),
        .b    (mul_b),
        .p    (prod)
    );

    word_t                 fix_p;
    logic signed [WORD_BITS:0] mag_sum;
    logic [COUNT_BITS-1:0] q_div;
    logic [COUNT_BITS-1:0] digit_full;

    assign fix_p      = fix_product(prod);
    assign mag_sum    = (WORD_BITS+1)'(xx_reg) + (WORD_BITS+1)'(yy_reg);
    assign q_div      = div10(q_reg);
    assign digit_full = q_reg - ((q_div << 3) + (q_div << 1));

    always_comb begin
        state_next     = state_reg;
        col_next       = col_reg;
        row_next       = row_reg;
        cx_next        = cx_reg;
        cy_next        = cy_reg;
        x_next         = x_reg;
        y_next         = y_reg;
        xx_next        = xx_reg;
        yy_next        = yy_reg;
        count_next     = count_reg;
        esc_next       = esc_reg;
        q_next         = q_reg;
        dig_cnt_next   = dig_cnt_reg;
        hund_next      = hund_reg;
        tens_next      = tens_reg;
        unit_next      = unit_reg;
        out_load       = 1'b0;
        mul_a          = x_reg;
        mul_b          = x_reg;

        unique case (state_reg)
            ST_IDLE: begin
                if (s_axis_tvalid) begin
                    col_next   = s_axis_tdata[9:0];
                    row_next   = s_axis_tdata[19:10];
                    state_next = ST_CX;
                end
            end
            ST_CX: begin
                mul_a      = WORD_BITS'(col_reg) & IDX_MASK;
                mul_b      = WORD_BITS'(step_reg);
                state_next = ST_CY;
            end
            ST_CY: begin
                cx_next    = sat_word(PROD_BITS'(origin_re_reg) + prod);
                mul_a      = WORD_BITS'(row_reg) & IDX_MASK;
                mul_b      = WORD_BITS'(step_reg);
                state_next = ST_CI;
            end
            ST_CI: begin
                cy_next    = sat_word(PROD_BITS'(origin_im_reg) + prod);
                x_next     = '0;
                y_next     = '0;
                count_next = '0;
                state_next = ST_XX;
            end
            ST_XX: begin
                if (count_reg >= limit_reg) begin
                    esc_next     = 1'b0;
                    q_next       = count_reg;
                    dig_cnt_next = '0;
                    state_next   = ST_DIG;
                end else begin
                    state_next = ST_YY;
                end
            end
            ST_YY: begin
                xx_next    = fix_p;
                mul_a      = y_reg;
                mul_b      = y_reg;
                state_next = ST_XY;
            end
            ST_XY: begin
                yy_next    = fix_p;
                mul_a      = x_reg;
                mul_b      = y_reg;
                state_next = ST_UPD;
            end
            ST_UPD: begin
                if (mag_sum >= FOUR) begin
                    esc_next     = 1'b1;
                    q_next       = count_reg;
                    dig_cnt_next = '0;
                    state_next   = ST_DIG;
                end else begin
                    x_next     = sat_add(sat_sub(xx_reg, yy_reg), cx_reg);
                    y_next     = sat_add(sat_add(fix_p, fix_p), cy_reg);
                    count_next = count_reg + COUNT_BITS'(1);
                    state_next = ST_XX;
                end
            end
            ST_DIG: begin
                // one decimal digit per cycle, units first
                unit_next    = tens_reg;
                tens_next    = hund_reg;
                hund_next    = digit_full[DIGIT_BITS-1:0];
                q_next       = q_div;
                dig_cnt_next = dig_cnt_reg + 2'd1;
                if (dig_cnt_reg == 2'd2) begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                if (!out_valid_reg || m_axis_tready) begin
                    out_load   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        out_valid_next = out_valid_reg;
        if (out_load) begin
            out_valid_next = 1'b1;
        end else if (m_axis_tready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        col_reg     <= col_next;
        row_reg     <= row_next;
        cx_reg      <= cx_next;
        cy_reg      <= cy_next;
        x_reg       <= x_next;
        y_reg       <= y_next;
        xx_reg      <= xx_next;
        yy_reg      <= yy_next;
        count_reg   <= count_next;
        esc_reg     <= esc_next;
        q_reg       <= q_next;
        dig_cnt_reg <= dig_cnt_next;
        hund_reg    <= hund_next;
        tens_reg    <= tens_next;
        unit_reg    <= unit_next;
        if (out_load) begin
            out_count_reg <= count_reg;
            out_esc_reg   <= esc_reg;
            out_red_reg   <= esc_reg ? hund_reg : '0;
            out_green_reg <= esc_reg ? tens_reg : '0;
            out_blue_reg  <= esc_reg ? unit_reg : '0;
        end
    end

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {out_blue_reg, out_green_reg, out_red_reg, out_count_reg};
    assign m_axis_tuser  = out_esc_reg;

endmodule

FILE: hdl/mep_mul.sv
`timescale 1ns / 1ps

module mep_mul (
    input  logic           aclk,
    input  mep_pkg::word_t a,
    input  mep_pkg::word_t b,
    output mep_pkg::prod_t p
);
    import mep_pkg::*;

    prod_t p_reg;

    always_ff @(posedge aclk) begin
        p_reg <= PROD_BITS'(a) * PROD_BITS'(b);
    end

    assign p = p_reg;

endmodule

FILE: hdl/mep_checker.sv
`timescale 1ns / 1ps

module mep_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [23:0] m_axis_tdata,
    input logic        m_axis_tuser
);
    import mep_pkg::*;

    logic [COUNT_BITS-1:0] cnt;
    logic [DIGIT_BITS-1:0] red, green, blue;
    logic [COUNT_BITS-1:0] dec;

    assign cnt   = m_axis_tdata[11:0];
    assign red   = m_axis_tdata[15:12];
    assign green = m_axis_tdata[19:16];
    assign blue  = m_axis_tdata[23:20];
    assign dec   = COUNT_BITS'(red) * COUNT_BITS'(100) + COUNT_BITS'(green) * COUNT_BITS'(10)
                 + COUNT_BITS'(blue);

    // stalled result holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
        else $error("result changed while stalled");

    // one pixel in flight: an accepted request closes the input
    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("request taken while core busy");

    a_inside_black: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && !m_axis_tuser |-> red == '0 && green == '0 && blue == '0)
        else $error("colour digits set on a point inside the set");

    a_digits_match: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && m_axis_tuser && cnt < COUNT_BITS'(1000) |-> dec == cnt)
        else $error("colour digits do not match escape count");

endmodule

bind mandelbrot_escape_pixel_core mep_checker u_mep_checker (.*);
